[rtl/bat_pkg.sv]
package bat_pkg;

    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChEqual  = 8'h3D;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChEnd    = 8'h00;

    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCountW  = $clog2(QDepth + 1);

    typedef enum logic [2:0] {
        M_SKIP   = 3'd0,
        M_KEY    = 3'd1,
        M_VSTART = 3'd2,
        M_UNQ    = 3'd3,
        M_QUOTED = 3'd4,
        M_ESC    = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        K_KEY   = 3'd0,
        K_VAL   = 3'd1,
        K_ENDNV = 3'd2,
        K_ENDV  = 3'd3,
        K_ERR   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[rtl/bat_parse.sv]
module bat_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output bat_pkg::t_push o_push
);
    import bat_pkg::*;

    t_mode r_mode;
    t_mode n_mode;
    t_push dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_SKIP;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        dec     = '0;
        dec.cnt = 2'd0;
        if (i_byte == ChEnd) begin
            n_mode = M_SKIP;
            case (r_mode)
                M_KEY: begin
                    dec.cnt     = 2'd1;
                    dec.r0.kind = K_ENDNV;
                end
                M_VSTART, M_UNQ, M_QUOTED: begin
                    dec.cnt     = 2'd1;
                    dec.r0.kind = K_ENDV;
                end
                M_ESC: begin
                    dec.cnt     = 2'd1;
                    dec.r0.kind = K_ERR;
                end
                default: begin
                    dec.cnt = 2'd0;
                end
            endcase
        end else begin
            case (r_mode)
                M_KEY: begin
                    if (i_byte == ChSpace) begin
                        dec.cnt     = 2'd1;
                        dec.r0.kind = K_ENDNV;
                        n_mode      = M_SKIP;
                    end else if (i_byte == ChEqual) begin
                        n_mode = M_VSTART;
                    end else begin
                        dec.cnt     = 2'd1;
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_KEY;
                    end
                end
                M_VSTART: begin
                    if (i_byte == ChQuote) begin
                        n_mode = M_QUOTED;
                    end else if (i_byte == ChSpace) begin
                        dec.cnt     = 2'd1;
                        dec.r0.kind = K_ENDV;
                        n_mode      = M_SKIP;
                    end else begin
                        dec.cnt     = 2'd1;
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_VAL;
                        n_mode      = M_UNQ;
                    end
                end
                M_UNQ: begin
                    dec.cnt = 2'd1;
                    if (i_byte == ChSpace) begin
                        dec.r0.kind = K_ENDV;
                        n_mode      = M_SKIP;
                    end else begin
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_VAL;
                    end
                end
                M_QUOTED: begin
                    if (i_byte == ChQuote) begin
                        dec.cnt     = 2'd1;
                        dec.r0.kind = K_ENDV;
                        n_mode      = M_SKIP;
                    end else if (i_byte == ChBslash) begin
                        n_mode = M_ESC;
                    end else begin
                        dec.cnt     = 2'd1;
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_VAL;
                    end
                end
                M_ESC: begin
                    n_mode = M_QUOTED;
                    if (i_byte != ChQuote && i_byte != ChBslash) begin
                        dec.cnt     = 2'd2;
                        dec.r0.data = ChBslash;
                        dec.r0.kind = K_VAL;
                        dec.r1.data = i_byte;
                        dec.r1.kind = K_VAL;
                    end else begin
                        dec.cnt     = 2'd1;
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_VAL;
                    end
                end
                default: begin
                    if (i_byte == ChSpace) begin
                        n_mode = M_SKIP;
                    end else if (i_byte == ChEqual) begin
                        n_mode = M_VSTART;
                    end else begin
                        dec.cnt     = 2'd1;
                        dec.r0.data = i_byte;
                        dec.r0.kind = K_KEY;
                        n_mode      = M_KEY;
                    end
                end
            endcase
        end
        dec.r0.last = (dec.cnt == 2'd1);
        dec.r1.last = (dec.cnt == 2'd2);
    end

    always_comb begin
        o_push = dec;
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

endmodule

[rtl/bat_outq.sv]
module bat_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bat_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output bat_pkg::t_result o_head
);
    import bat_pkg::*;

    t_result                r_mem [QDepth];
    logic [QPtrW-1:0]       r_wr_ptr;
    logic [QPtrW-1:0]       r_rd_ptr;
    logic [QCountW-1:0]     r_count;
    logic [QCountW-1:0]     n_count;
    logic [QPtrW-1:0]       wr_ptr_1;

    assign wr_ptr_1 = r_wr_ptr + QPtrW'(1);
    assign n_count  = r_count + QCountW'(i_push.cnt) - QCountW'(i_pop);
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= QCountW'(QDepth - 2));
    assign o_head   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPtrW'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + QPtrW'(i_pop);
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCountW'(QDepth))
        else $error("result queue count exceeds its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("result pushed without room for two entries");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - QCountW'(1)))
        else $error("queue count did not drop after a pop");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty result queue");
`endif

endmodule

[rtl/boot_argument_tokenizer_unit.sv]
// Boot argument tokenizer.
// The input channel carries one command-line text byte per transaction; a zero
// byte ends the text and rearms the parser. The output channel carries one
// result per transaction: a key byte, a value byte, an end marker with or
// without value, or an error, with o_last set on the final result of a byte.
// A byte is decoded in the cycle it is accepted and its results are written
// into a four-entry result queue, whose registers drive the output. One byte
// is accepted per cycle while the queue holds at most two results. A byte
// inside a quoted value that follows a backslash and
// is neither quote nor backslash yields two results, but the backslash before
// it yields none, so while the receiver takes one result per cycle the queue
// never holds more than two results and the input is never stalled.
// When the receiver stalls, results stay in the queue and o_in_stall rises
// once fewer than two entries are free. Synchronous reset empties the queue
// and returns the parser to skipping leading spaces.
module boot_argument_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_kind,
    output logic       o_last
);
    import bat_pkg::*;

    logic    in_accept;
    logic    room;
    t_push   push;
    t_result head;

    assign o_in_stall = !room;
    assign in_accept  = i_in_valid && room;

    bat_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_push   (push)
    );

    bat_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_out_byte = head.data;
    assign o_kind     = head.kind;
    assign o_last     = head.last;

endmodule
